/* sv/assert_macros.svh */
// concurrent assertion helpers, sampled on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/fpa2_pkg.sv */
package fpa2_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned QuoW    = 16;
  localparam int unsigned RemW    = 17;
  localparam int unsigned DivCells = 16;

  localparam logic [11:0] PolyK1 = 12'd2847;
  localparam logic [13:0] PolyK2 = 14'd11039;
  localparam logic [14:0] Q15Half = 15'h4000;

  localparam logic [AngleW-1:0] AngEighth        = 16'd8192;
  localparam logic [AngleW-1:0] AngFiveEighths   = 16'd40960;
  localparam logic [AngleW-1:0] AngQuarter       = 16'd16384;
  localparam logic [AngleW-1:0] AngHalf          = 16'd32768;
  localparam logic [AngleW-1:0] AngThreeQuarters = 16'd49152;
  localparam logic [AngleW-1:0] AngZero          = 16'd0;

  // per-request info carried alongside the divider and polynomial
  typedef struct packed {
    logic              special;  // equal inputs, base is the answer
    logic              sub_u;    // angle = base - u instead of base + u
    logic              neg_r;    // quotient is negative
    logic [AngleW-1:0] base;
  } side_t;

  // partial division state
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] den;
    logic [QuoW-1:0] quo;
  } div_t;

endpackage

/* sv/fpa2_div_cell.sv */
`include "assert_macros.svh"

module fpa2_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  fpa2_pkg::div_t  in_div,
  input  fpa2_pkg::side_t in_side,
  output logic            out_vld,
  output fpa2_pkg::div_t  out_div,
  output fpa2_pkg::side_t out_side
);

  logic [fpa2_pkg::RemW:0]   diff;
  logic                      qbit;
  logic [fpa2_pkg::RemW-1:0] rem_kept;
  fpa2_pkg::div_t            div_next;

  assign diff     = {1'b0, in_div.rem} - {2'b00, in_div.den};
  assign qbit     = ~diff[fpa2_pkg::RemW];
  assign rem_kept = qbit ? diff[fpa2_pkg::RemW-1:0] : in_div.rem;

  // remainder is below the divisor here, so doubling stays in range
  always_comb begin
    div_next.rem = {rem_kept[fpa2_pkg::RemW-2:0], 1'b0};
    div_next.den = in_div.den;
    div_next.quo = {in_div.quo[fpa2_pkg::QuoW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_div  <= div_next;
      out_side <= in_side;
    end
  end

  `ASSERT_CLK(a_rem_bound,
    out_vld && (out_div.den != '0) |-> out_div.rem < {out_div.den, 1'b0},
    "divider remainder not below twice the divisor")

endmodule

/* sv/fpa2_poly.sv */
`include "assert_macros.svh"

module fpa2_poly (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [fpa2_pkg::QuoW-1:0]   in_quo,
  input  fpa2_pkg::side_t             in_side,
  output logic                        out_vld,
  output logic signed [31:0]          out_prod,
  output fpa2_pkg::side_t             out_side
);

  // stage 1: 2847 * |r|
  logic                 v1;
  logic [27:0]          p1;
  logic [15:0]          q1;
  fpa2_pkg::side_t      s1;

  // stage 2: rounded correction, k and signed r
  logic [27:0]          sum1;
  logic [12:0]          corr;
  logic [13:0]          k_next;
  logic signed [16:0]   r_next;
  logic                 v2;
  logic [13:0]          k2;
  logic signed [16:0]   r2;
  fpa2_pkg::side_t      s2;

  logic signed [31:0]   prod_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= 28'(fpa2_pkg::PolyK1 * in_quo);
      q1 <= in_quo;
      s1 <= in_side;
    end
  end

  // skip the half-lsb bump when the fraction is exactly one half
  assign sum1   = p1 + ((p1[14:0] == fpa2_pkg::Q15Half) ? 28'd0 : {13'd0, fpa2_pkg::Q15Half});
  assign corr   = sum1[27:15];
  assign k_next = fpa2_pkg::PolyK2 - {1'b0, corr};
  assign r_next = s1.neg_r ? -$signed({1'b0, q1}) : $signed({1'b0, q1});

  always_ff @(posedge clk) begin
    if (en) begin
      k2 <= k_next;
      r2 <= r_next;
      s2 <= s1;
    end
  end

  assign prod_next = $signed({1'b0, k2}) * r2;

  always_ff @(posedge clk) begin
    if (en) begin
      out_prod <= prod_next;
      out_side <= s2;
    end
  end

  // equal inputs bypass the polynomial, a zero pair leaves an all-ones quotient
  `ASSERT_CLK(a_k_range,
    v2 && !s2.special |-> (k2 >= 14'd8191) && (k2 <= fpa2_pkg::PolyK2),
    "polynomial coefficient out of range")

endmodule

/* sv/fixed_point_atan2_top.sv */
// four-quadrant arctangent, one (y, x) request per cycle, fully pipelined
// pipeline from request accept to angle valid: input register, 16 restoring
// divider cells, 3 polynomial stages, output register
// throughput: one request per cycle; the whole pipe holds while out_stall
// blocks a valid result
// reset: synchronous rst clears all stage valid bits, no clearing pass
`include "assert_macros.svh"

module fixed_point_atan2_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] y_coord,
  input  logic signed [15:0] x_coord,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] angle
);

  localparam int unsigned Cells = fpa2_pkg::DivCells;

  logic                          adv;
  logic [15:0]                   ay;
  logic [15:0]                   ax;
  logic                          xdom;
  fpa2_pkg::div_t                div_in;
  fpa2_pkg::side_t               side_in;

  logic                          vld_chain  [0:Cells];
  fpa2_pkg::div_t                div_chain  [0:Cells];
  fpa2_pkg::side_t               side_chain [0:Cells];

  logic                          pv;
  logic signed [31:0]            prod;
  fpa2_pkg::side_t               pside;
  logic signed [31:0]            psum;
  logic [15:0]                   u;
  logic [15:0]                   angle_next;

  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  assign ay   = y_coord[15] ? (~y_coord + 16'd1) : y_coord;
  assign ax   = x_coord[15] ? (~x_coord + 16'd1) : x_coord;
  assign xdom = ax > ay;

  always_comb begin
    div_in.rem = {1'b0, xdom ? ay : ax};
    div_in.den = xdom ? ax : ay;
    div_in.quo = '0;
    side_in.neg_r = y_coord[15] ^ x_coord[15];
    side_in.sub_u = ~xdom;
    side_in.special = (x_coord == y_coord);
    if (x_coord == y_coord) begin
      if (y_coord == 16'sd0) begin
        side_in.base = fpa2_pkg::AngZero;
      end else if (y_coord[15]) begin
        side_in.base = fpa2_pkg::AngFiveEighths;
      end else begin
        side_in.base = fpa2_pkg::AngEighth;
      end
    end else if (xdom) begin
      side_in.base = x_coord[15] ? fpa2_pkg::AngHalf : fpa2_pkg::AngZero;
    end else begin
      side_in.base = y_coord[15] ? fpa2_pkg::AngThreeQuarters : fpa2_pkg::AngQuarter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_chain[0] <= 1'b0;
    end else if (adv) begin
      vld_chain[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_chain[0]  <= div_in;
      side_chain[0] <= side_in;
    end
  end

  // one quotient bit per cell, msb first
  for (genvar i = 0; i < Cells; i++) begin : g_div
    fpa2_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (vld_chain[i]),
      .in_div   (div_chain[i]),
      .in_side  (side_chain[i]),
      .out_vld  (vld_chain[i+1]),
      .out_div  (div_chain[i+1]),
      .out_side (side_chain[i+1])
    );
  end

  fpa2_poly u_poly (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (vld_chain[Cells]),
    .in_quo   (div_chain[Cells].quo),
    .in_side  (side_chain[Cells]),
    .out_vld  (pv),
    .out_prod (prod),
    .out_side (pside)
  );

  assign psum = prod + ((prod[14:0] == fpa2_pkg::Q15Half) ? 32'sd0
                        : $signed({17'd0, fpa2_pkg::Q15Half}));
  assign u    = psum[30:15];

  always_comb begin
    priority if (pside.special) begin
      angle_next = pside.base;
    end else if (pside.sub_u) begin
      angle_next = pside.base - u;
    end else begin
      angle_next = pside.base + u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle <= angle_next;
    end
  end

  `ASSERT_CLK(a_quo_range,
    vld_chain[Cells] && !side_chain[Cells].special |-> div_chain[Cells].quo <= 16'd32768,
    "quotient above one in q15")

  `ASSERT_CLK_ALWAYS(a_stall_when_blocked,
    in_stall == (out_valid && out_stall),
    "input stall does not match a blocked output")

endmodule
